FILE: hw/rtl/aip_pkg.sv
// shared types and constants for the ipd frame parser
// no dependencies; used by the top level, parser core and result register
`default_nettype none

package aip_pkg;

  localparam int BUFFER_BYTES    = 64;
  localparam int COUNT_CHARS_MAX = 15;

  // longest payload a header may announce
  localparam logic [7:0] LEN_CAP       = 8'(BUFFER_BYTES - 1);
  localparam logic [3:0] COUNT_LIMIT   = 4'(COUNT_CHARS_MAX);
  localparam logic [7:0] SERVER_CH_RST = 8'd52;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam int IPD_LEN   = 4;
  localparam int READY_LEN = 5;

  localparam logic [7:0] IPD_TEXT [IPD_LEN] = '{8'h49, 8'h50, 8'h44, 8'h2c};
  localparam logic [7:0] READY_TEXT [READY_LEN] = '{8'h72, 8'h65, 8'h61, 8'h64, 8'h79};

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] channel;
    logic [7:0] msg_length;
    logic [7:0] data;
    logic       from_server;
    logic       last;
  } result_t;

  // core to output register
  typedef struct packed {
    logic    load;
    result_t res;
  } out_load_t;

endpackage

`default_nettype wire

FILE: hw/rtl/at_ipd_frame_parser_top.sv
// ipd frame parser: finds "IPD," frames and "ready" in a received byte stream
// Channels:
//   in_*   one received byte per word (in_valid / in_stall)
//   out_*  one result per word: header, payload byte or module restart
//   cfg_*  write of the server channel character; cfg_ready is always high
// Path: a taken byte waits in the input register; the result register then
//   loads its result and raises out_valid.
//   Throughput: one byte per cycle unless a result waits on out_stall; the
//   parser state is updated in a single pass of the state machine logic.
// Bytes that cause no result pass through without needing the result register,
//   so they keep flowing even while a result waits to be taken.
// Stall: when out_stall holds a result and the next byte also has a result,
//   that byte waits in the input register and in_stall goes high.
// Reset: synchronous, active low. Parser returns to hunting, all counters
//   clear, the server channel returns to '4', both registers empty.
// User writes configuration only when no frame is in flight; not enforced.
// depends on aip_pkg, aip_in_reg, aip_parser_core, aip_out_reg
`default_nettype none

module at_ipd_frame_parser_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_channel,
  output logic [7:0]      out_msg_length,
  output logic [7:0]      out_data,
  output logic            out_from_server,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_server_channel
);

  logic               item_valid;
  logic [7:0]         item_byte;
  logic               advance;
  logic               out_space;
  logic [7:0]         server_ch_r;
  aip_pkg::out_load_t out_load;
  aip_pkg::result_t   out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_ch_r <= aip_pkg::SERVER_CH_RST;
    end else if (cfg_valid && cfg_ready) begin
      server_ch_r <= cfg_server_channel;
    end
  end

  aip_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  aip_parser_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_byte      (item_byte),
    .out_space      (out_space),
    .server_channel (server_ch_r),
    .advance        (advance),
    .out_load       (out_load)
  );

  aip_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_load  (out_load),
    .out_space (out_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_channel     = out_res.channel;
  assign out_msg_length  = out_res.msg_length;
  assign out_data        = out_res.data;
  assign out_from_server = out_res.from_server;
  assign out_last        = out_res.last;

endmodule

`default_nettype wire

FILE: hw/rtl/aip_in_reg.sv
// input register of the ipd frame parser: holds one received word
// depends on aip_pkg only through the top level wiring (no package use)
`default_nettype none

module aip_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       advance,
  output logic            item_valid,
  output logic [7:0]      item_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // slot frees whenever the held word moves on
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;

endmodule

`default_nettype wire

FILE: hw/rtl/aip_parser_core.sv
// parser state machine: matchers, count conversion and payload counting
// depends on aip_pkg
`default_nettype none

module aip_parser_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  input  wire logic [7:0]         item_byte,
  input  wire logic               out_space,
  input  wire logic [7:0]         server_channel,
  output logic                    advance,
  output aip_pkg::out_load_t      out_load
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CHAN    = 3'd1,
    PH_SEP     = 3'd2,
    PH_COUNT   = 3'd3,
    PH_DROP    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CV_SPACE  = 2'd0,
    CV_DIGITS = 2'd1,
    CV_DONE   = 2'd2
  } cv_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] ipd_pos_r, ipd_pos_nxt;
  logic [2:0] rdy_pos_r, rdy_pos_nxt;
  logic [7:0] chan_r, chan_nxt;
  logic [7:0] accum_r, accum_nxt;
  logic [3:0] seen_r, seen_nxt;
  cv_t        cv_r, cv_nxt;
  logic       neg_r, neg_nxt;
  logic [7:0] left_r, left_nxt;

  logic              has_res;
  aip_pkg::result_t  res;
  logic [7:0]        c;
  logic              is_digit;
  logic              is_space;
  logic              ipd_hit;
  logic              rdy_hit;
  logic [2:0]        ipd_step;
  logic [2:0]        rdy_step;
  logic              fin;
  logic              fin_drop;
  logic [7:0]        fin_val;
  logic [7:0]        fin_len;
  logic [7:0]        dec_left;

  assign c        = item_byte;
  assign is_digit = (c >= aip_pkg::CH_ZERO) && (c <= aip_pkg::CH_NINE);
  assign is_space = (c == aip_pkg::CH_SPACE) || (c inside {[aip_pkg::CH_TAB:aip_pkg::CH_CR]});
  assign ipd_hit  = (ipd_pos_r < 3'(aip_pkg::IPD_LEN)) &&
                    (c == aip_pkg::IPD_TEXT[ipd_pos_r[1:0]]);
  assign rdy_hit  = (rdy_pos_r < 3'(aip_pkg::READY_LEN)) &&
                    (c == aip_pkg::READY_TEXT[rdy_pos_r]);
  assign ipd_step = ipd_hit ? ipd_pos_r + 3'd1 : 3'd0;
  assign rdy_step = rdy_hit ? rdy_pos_r + 3'd1 : 3'd0;
  assign dec_left = left_r - 8'd1;

  // a word leaves the input register unless it has a result with nowhere to go
  assign advance = item_valid && (!has_res || out_space);

  always_comb begin
    phase_nxt   = phase_r;
    ipd_pos_nxt = ipd_pos_r;
    rdy_pos_nxt = rdy_pos_r;
    chan_nxt    = chan_r;
    accum_nxt   = accum_r;
    seen_nxt    = seen_r;
    cv_nxt      = cv_r;
    neg_nxt     = neg_r;
    left_nxt    = left_r;
    has_res     = 1'b0;
    res         = '0;
    fin         = 1'b0;
    fin_drop    = 1'b0;
    fin_val     = 8'd0;
    fin_len     = 8'd0;

    case (phase_r)
      PH_HUNT: begin
        ipd_pos_nxt = ipd_step;
        rdy_pos_nxt = rdy_step;
        if (ipd_step == 3'(aip_pkg::IPD_LEN)) begin
          ipd_pos_nxt = 3'd0;
          rdy_pos_nxt = 3'd0;
          phase_nxt   = PH_CHAN;
        end else if (rdy_step == 3'(aip_pkg::READY_LEN)) begin
          ipd_pos_nxt = 3'd0;
          rdy_pos_nxt = 3'd0;
          has_res     = 1'b1;
          res.kind    = aip_pkg::KIND_RESTART;
        end
      end
      PH_CHAN: begin
        chan_nxt  = c;
        phase_nxt = PH_SEP;
      end
      PH_SEP: begin
        accum_nxt = 8'd0;
        seen_nxt  = 4'd0;
        cv_nxt    = CV_SPACE;
        neg_nxt   = 1'b0;
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        if (c == aip_pkg::CH_COLON) begin
          fin = 1'b1;
        end else begin
          // atoi-style: whitespace, one sign, then digits
          if (cv_r == CV_SPACE && is_space) begin
            cv_nxt = CV_SPACE;
          end else if (cv_r == CV_SPACE &&
                       (c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS)) begin
            neg_nxt = (c == aip_pkg::CH_MINUS);
            cv_nxt  = CV_DIGITS;
          end else if (cv_r == CV_SPACE || cv_r == CV_DIGITS) begin
            if (is_digit) begin
              accum_nxt = {accum_r[4:0], 3'd0} + {accum_r[6:0], 1'b0} +
                          (c - aip_pkg::CH_ZERO);
              cv_nxt    = CV_DIGITS;
            end else begin
              cv_nxt = CV_DONE;
            end
          end
          seen_nxt = seen_r + 4'd1;
          if (seen_nxt >= aip_pkg::COUNT_LIMIT) begin
            fin      = 1'b1;
            fin_drop = 1'b1;
          end
        end
        if (fin) begin
          fin_val  = neg_nxt ? (8'd0 - accum_nxt) : accum_nxt;
          fin_len  = (fin_val < aip_pkg::LEN_CAP) ? fin_val : aip_pkg::LEN_CAP;
          left_nxt = fin_len;
          if (fin_drop) begin
            phase_nxt = PH_DROP;
          end else begin
            phase_nxt = (fin_len != 8'd0) ? PH_PAYLOAD : PH_HUNT;
          end
          has_res         = 1'b1;
          res.kind        = aip_pkg::KIND_HEADER;
          res.channel     = chan_r;
          res.msg_length  = fin_len;
          res.from_server = (chan_r == server_channel);
          res.last        = (fin_len == 8'd0);
        end
      end
      PH_DROP: begin
        phase_nxt = (left_r != 8'd0) ? PH_PAYLOAD : PH_HUNT;
      end
      PH_PAYLOAD: begin
        left_nxt = dec_left;
        if (dec_left == 8'd0) begin
          phase_nxt = PH_HUNT;
        end
        has_res         = 1'b1;
        res.kind        = aip_pkg::KIND_PAYLOAD;
        res.channel     = chan_r;
        res.data        = c;
        res.from_server = (chan_r == server_channel);
        res.last        = (dec_left == 8'd0);
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign out_load.load = advance && has_res;
  assign out_load.res  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      ipd_pos_r <= 3'd0;
      rdy_pos_r <= 3'd0;
      chan_r    <= 8'd0;
      accum_r   <= 8'd0;
      seen_r    <= 4'd0;
      cv_r      <= CV_SPACE;
      neg_r     <= 1'b0;
      left_r    <= 8'd0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      ipd_pos_r <= ipd_pos_nxt;
      rdy_pos_r <= rdy_pos_nxt;
      chan_r    <= chan_nxt;
      accum_r   <= accum_nxt;
      seen_r    <= seen_nxt;
      cv_r      <= cv_nxt;
      neg_r     <= neg_nxt;
      left_r    <= left_nxt;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 8'd0)
    else $error("payload phase with nothing left");

  a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COUNT |-> seen_r < aip_pkg::COUNT_LIMIT)
    else $error("count phase past its character limit");

  a_matchers_reset: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HUNT |-> (ipd_pos_r == 3'd0 && rdy_pos_r == 3'd0))
    else $error("matcher left running outside hunting");

  a_header_capped: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r <= aip_pkg::LEN_CAP)
    else $error("payload count above buffer cap");

endmodule

`default_nettype wire

FILE: hw/rtl/aip_out_reg.sv
// result register of the ipd frame parser
// depends on aip_pkg for the result struct
`default_nettype none

module aip_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire aip_pkg::out_load_t   out_load,
  output logic                      out_space,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output aip_pkg::result_t          out_res
);

  logic             valid_r, valid_nxt;
  aip_pkg::result_t res_r;

  assign out_space = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (out_load.load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load.load) begin
      res_r <= out_load.res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_load.load |-> out_space)
    else $error("result loaded over a word still waiting");

endmodule

`default_nettype wire
